FILE: rtl/core/tfs_pkg.sv
// Shared widths, microcode codes and the control store of the factor search.
package tfs_pkg;

  localparam int unsigned CW = 16;
  localparam int unsigned NW = 2 * CW;
  localparam int unsigned EW = CW + 1;
  localparam int unsigned CNTW = $clog2(CW + 1);
  localparam int unsigned PCW = 4;

  localparam logic [CW-1:0] MAXC = {CW{1'b1}};
  localparam logic [CW-1:0] MAXC_M1 = MAXC - CW'(1);
  localparam logic [NW-1:0] MAXSQ = NW'(MAXC) * NW'(MAXC);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_SET_A,
    OP_DIV_A,
    OP_INIT_BEST,
    OP_EVAL,
    OP_INC_A,
    OP_EMIT,
    OP_LD_ZERO,
    OP_LD_RANGE
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_IDLE,
    C_DIVB,
    C_ZERO,
    C_OVER,
    C_AEND,
    C_EXACT
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [PCW-1:0]    target;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic n_zero;
    logic n_over;
    logic a_end;
    logic exact;
  } flags_t;

  // Program step addresses.
  localparam logic [PCW-1:0] S_IDLE      = 4'd0;
  localparam logic [PCW-1:0] S_CHK_ZERO  = 4'd1;
  localparam logic [PCW-1:0] S_CHK_OVER  = 4'd2;
  localparam logic [PCW-1:0] S_SET_A     = 4'd3;
  localparam logic [PCW-1:0] S_FIRST     = 4'd4;
  localparam logic [PCW-1:0] S_FIRST_WT  = 4'd5;
  localparam logic [PCW-1:0] S_INIT      = 4'd6;
  localparam logic [PCW-1:0] S_LOOP      = 4'd7;
  localparam logic [PCW-1:0] S_DIV       = 4'd8;
  localparam logic [PCW-1:0] S_DIV_WAIT  = 4'd9;
  localparam logic [PCW-1:0] S_EVAL      = 4'd10;
  localparam logic [PCW-1:0] S_INC       = 4'd11;
  localparam logic [PCW-1:0] S_DONE      = 4'd12;
  localparam logic [PCW-1:0] S_ZERO      = 4'd13;
  localparam logic [PCW-1:0] S_RANGE     = 4'd14;

  function automatic ctrl_t rom(input logic [PCW-1:0] pc);
    ctrl_t w;
    case (pc)
      S_IDLE:      w = '{OP_LATCH,     C_IDLE,   S_IDLE};
      S_CHK_ZERO:  w = '{OP_NOP,       C_ZERO,   S_ZERO};
      S_CHK_OVER:  w = '{OP_NOP,       C_OVER,   S_RANGE};
      S_SET_A:     w = '{OP_SET_A,     C_NEXT,   S_IDLE};
      S_FIRST:     w = '{OP_DIV_A,     C_NEXT,   S_IDLE};
      S_FIRST_WT:  w = '{OP_NOP,       C_DIVB,   S_FIRST_WT};
      S_INIT:      w = '{OP_INIT_BEST, C_NEXT,   S_IDLE};
      S_LOOP:      w = '{OP_NOP,       C_AEND,   S_DONE};
      S_DIV:       w = '{OP_DIV_A,     C_NEXT,   S_IDLE};
      S_DIV_WAIT:  w = '{OP_NOP,       C_DIVB,   S_DIV_WAIT};
      S_EVAL:      w = '{OP_EVAL,      C_EXACT,  S_DONE};
      S_INC:       w = '{OP_INC_A,     C_ALWAYS, S_LOOP};
      S_DONE:      w = '{OP_EMIT,      C_ALWAYS, S_IDLE};
      S_ZERO:      w = '{OP_LD_ZERO,   C_ALWAYS, S_DONE};
      S_RANGE:     w = '{OP_LD_RANGE,  C_ALWAYS, S_DONE};
      default:     w = '{OP_NOP,       C_ALWAYS, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/tfs_div.sv
// Restoring divider: one quotient bit per cycle, quotient known to fit in CW bits.
module tfs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tfs_pkg::NW-1:0]    dividend_i,
  input  logic [tfs_pkg::CW-1:0]    divisor_i,
  output logic                      busy_o,
  output logic [tfs_pkg::CW-1:0]    quot_o,
  output logic [tfs_pkg::CW-1:0]    rem_o
);

  logic [tfs_pkg::CW-1:0]   rem_q, rem_d;
  logic [tfs_pkg::CW-1:0]   quo_q, quo_d;
  logic [tfs_pkg::CW-1:0]   dvs_q, dvs_d;
  logic [tfs_pkg::CNTW-1:0] cnt_q, cnt_d;
  logic [tfs_pkg::CW:0]     trial;
  logic [tfs_pkg::CW:0]     diff;
  logic                     ge;

  // The low half of the dividend shifts out as quotient bits shift in.
  always_comb begin
    trial = {rem_q, quo_q[tfs_pkg::CW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = dividend_i[tfs_pkg::NW-1:tfs_pkg::CW];
      quo_d = dividend_i[tfs_pkg::CW-1:0];
      dvs_d = divisor_i;
      cnt_d = tfs_pkg::CNTW'(tfs_pkg::CW);
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[tfs_pkg::CW-1:0] : trial[tfs_pkg::CW-1:0];
      quo_d = {quo_q[tfs_pkg::CW-2:0], ge};
      cnt_d = cnt_q - tfs_pkg::CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/tfs_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module tfs_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tfs_pkg::flags_t flags_i,
  output tfs_pkg::op_e    op_o,
  output logic            busy_o
);

  logic [tfs_pkg::PCW-1:0] pc_q, pc_d;
  tfs_pkg::ctrl_t          ctrl;
  logic                    jump;

  always_comb begin
    ctrl = tfs_pkg::rom(pc_q);
    case (ctrl.cond)
      tfs_pkg::C_NEXT:   jump = 1'b0;
      tfs_pkg::C_ALWAYS: jump = 1'b1;
      tfs_pkg::C_IDLE:   jump = !start_i;
      tfs_pkg::C_DIVB:   jump = flags_i.div_busy;
      tfs_pkg::C_ZERO:   jump = flags_i.n_zero;
      tfs_pkg::C_OVER:   jump = flags_i.n_over;
      tfs_pkg::C_AEND:   jump = flags_i.a_end;
      tfs_pkg::C_EXACT:  jump = flags_i.exact;
      default:           jump = 1'b1;
    endcase
    pc_d = jump ? ctrl.target : pc_q + tfs_pkg::PCW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tfs_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o   = ctrl.op;
  assign busy_o = pc_q != tfs_pkg::S_IDLE;

endmodule

FILE: rtl/core/tfs_dp.sv
// Search datapath: target, candidate prescaler, best pair and its error.
module tfs_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tfs_pkg::NW-1:0]    target_count_i,
  input  tfs_pkg::op_e              op_i,
  output tfs_pkg::flags_t           flags_o,
  output logic                      done_o,
  output logic [tfs_pkg::CW-1:0]    prescale_count_o,
  output logic [tfs_pkg::CW-1:0]    period_count_o,
  output logic signed [tfs_pkg::EW-1:0] product_error_o,
  output logic                      out_of_range_o
);

  logic [tfs_pkg::NW-1:0]        n_q;
  logic [tfs_pkg::CW-1:0]        a_q;
  logic [tfs_pkg::CW-1:0]        best_a_q;
  logic [tfs_pkg::CW-1:0]        best_b_q;
  logic [tfs_pkg::NW-1:0]        best_abs_q;
  logic signed [tfs_pkg::EW-1:0] best_err_q;
  logic                          range_q;
  logic                          done_q;

  logic                          div_start;
  logic                          div_busy;
  logic [tfs_pkg::CW-1:0]        quot;
  logic [tfs_pkg::CW-1:0]        rem;

  logic [tfs_pkg::NW-1:0]        n_m1;
  logic [tfs_pkg::CW:0]          ceil_sum;
  logic [tfs_pkg::CW-1:0]        ceil_q;

  logic [tfs_pkg::CW-1:0]        cand_b;
  logic [tfs_pkg::NW-1:0]        cand_abs;
  logic signed [tfs_pkg::EW-1:0] cand_err;
  logic [tfs_pkg::CW-1:0]        up_err;
  logic                          better;
  logic [tfs_pkg::NW-1:0]        over_diff;
  logic signed [tfs_pkg::EW-1:0] range_err;

  assign div_start = op_i == tfs_pkg::OP_DIV_A;

  tfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (a_q),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Since 65536 leaves one over a multiple of 65535, (n - 1) / 65535 is the high
  // half plus a correction of zero, one or two from the sum of both halves.
  always_comb begin
    n_m1     = n_q - tfs_pkg::NW'(1);
    ceil_sum = {1'b0, n_m1[tfs_pkg::NW-1:tfs_pkg::CW]} + {1'b0, n_m1[tfs_pkg::CW-1:0]};
    ceil_q   = n_m1[tfs_pkg::NW-1:tfs_pkg::CW];
    if (ceil_sum >= {1'b0, tfs_pkg::MAXC}) begin
      ceil_q = ceil_q + tfs_pkg::CW'(1);
    end
    if (ceil_sum >= {tfs_pkg::MAXC, 1'b0}) begin
      ceil_q = ceil_q + tfs_pkg::CW'(1);
    end
  end

  // Round the period up when the remainder exceeds half the prescaler. A period
  // that wraps to zero has error equal to the target and can never win.
  always_comb begin
    up_err = a_q - rem;
    if (rem <= (a_q >> 1)) begin
      cand_b   = quot;
      cand_abs = tfs_pkg::NW'(rem);
      cand_err = -$signed({1'b0, rem});
    end else if (quot == tfs_pkg::MAXC) begin
      cand_b   = '0;
      cand_abs = n_q;
      cand_err = '0;
    end else begin
      cand_b   = quot + tfs_pkg::CW'(1);
      cand_abs = tfs_pkg::NW'(up_err);
      cand_err = $signed({1'b0, up_err});
    end
    better = cand_abs < best_abs_q;
  end

  // Above range the error is negative and saturates at -65535 in its 17-bit field.
  always_comb begin
    over_diff = n_q - tfs_pkg::MAXSQ;
    if (over_diff > tfs_pkg::NW'(tfs_pkg::MAXC)) begin
      range_err = -$signed({1'b0, tfs_pkg::MAXC});
    end else begin
      range_err = -$signed({1'b0, over_diff[tfs_pkg::CW-1:0]});
    end
  end

  always_comb begin
    flags_o.div_busy = div_busy;
    flags_o.n_zero   = n_q == '0;
    flags_o.n_over   = n_q > tfs_pkg::MAXSQ;
    flags_o.a_end    = a_q >= tfs_pkg::MAXC_M1;
    flags_o.exact    = (op_i == tfs_pkg::OP_EVAL) && better && (cand_abs == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      range_q <= 1'b0;
    end else begin
      done_q <= op_i == tfs_pkg::OP_EMIT;
      case (op_i)
        tfs_pkg::OP_LD_RANGE:  range_q <= 1'b1;
        tfs_pkg::OP_LD_ZERO:   range_q <= 1'b0;
        tfs_pkg::OP_INIT_BEST: range_q <= 1'b0;
        default:               range_q <= range_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      tfs_pkg::OP_LATCH: begin
        n_q <= target_count_i;
      end
      tfs_pkg::OP_SET_A: begin
        a_q      <= ceil_q + tfs_pkg::CW'(1);
        best_a_q <= ceil_q + tfs_pkg::CW'(1);
      end
      tfs_pkg::OP_INIT_BEST: begin
        best_b_q   <= quot;
        best_err_q <= -$signed({1'b0, rem});
        best_abs_q <= n_q;
      end
      tfs_pkg::OP_EVAL: begin
        if (better) begin
          best_a_q   <= a_q;
          best_b_q   <= cand_b;
          best_abs_q <= cand_abs;
          best_err_q <= cand_err;
        end
      end
      tfs_pkg::OP_INC_A: begin
        a_q <= a_q + tfs_pkg::CW'(1);
      end
      tfs_pkg::OP_LD_ZERO: begin
        best_a_q   <= tfs_pkg::CW'(1);
        best_b_q   <= '0;
        best_err_q <= '0;
      end
      tfs_pkg::OP_LD_RANGE: begin
        best_a_q   <= tfs_pkg::MAXC;
        best_b_q   <= tfs_pkg::MAXC;
        best_err_q <= range_err;
      end
      default: begin
      end
    endcase
  end

  assign done_o           = done_q;
  assign prescale_count_o = best_a_q;
  assign period_count_o   = best_b_q;
  assign product_error_o  = best_err_q;
  assign out_of_range_o   = range_q;

endmodule

FILE: rtl/core/timer_divider_factor_search.sv
// Top level of the timer prescaler and period factor search.
//
//   channel   handshake          ports
//   -------   ----------------   ------------------------------------------------
//   command   start, busy        target_count_i
//   result    done_o (1 cycle)   prescale_count_o, period_count_o,
//                                product_error_o, out_of_range_o
//
// A word is taken when start is high and busy is low; one result word follows.
// Setup runs one division on the 16-step divider, and each candidate prescaler in the
// search loop then runs one more. Zero and out-of-range targets skip the search, and
// reset returns the sequencer to its idle step.
// Results cannot be held off by the receiver, and busy stays high until the
// result is shown.
module timer_divider_factor_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tfs_pkg::NW-1:0]        target_count_i,
  output logic                          done_o,
  output logic [tfs_pkg::CW-1:0]        prescale_count_o,
  output logic [tfs_pkg::CW-1:0]        period_count_o,
  output logic signed [tfs_pkg::EW-1:0] product_error_o,
  output logic                          out_of_range_o
);

  tfs_pkg::op_e    op;
  tfs_pkg::flags_t flags;

  tfs_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .op_o    (op),
    .busy_o  (busy)
  );

  tfs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .target_count_i   (target_count_i),
    .op_i             (op),
    .flags_o          (flags),
    .done_o           (done_o),
    .prescale_count_o (prescale_count_o),
    .period_count_o   (period_count_o),
    .product_error_o  (product_error_o),
    .out_of_range_o   (out_of_range_o)
  );

endmodule

FILE: rtl/core/tfs_chk.sv
// Port-level checker for the factor search, bound to the top level.
module tfs_chk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [tfs_pkg::NW-1:0]        target_count_i,
  input  logic                          done_o,
  input  logic [tfs_pkg::CW-1:0]        prescale_count_o,
  input  logic [tfs_pkg::CW-1:0]        period_count_o,
  input  logic signed [tfs_pkg::EW-1:0] product_error_o,
  input  logic                          out_of_range_o
);

  // An accepted command always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an accepted word");

  // A result word is shown only once the block has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // Out-of-range results carry the largest pair and a negative error.
  a_range_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> prescale_count_o == tfs_pkg::MAXC &&
      period_count_o == tfs_pkg::MAXC && product_error_o < 0)
    else $error("bad out-of-range result");

  a_prescale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> prescale_count_o != '0)
    else $error("zero prescaler in result");

endmodule

bind timer_divider_factor_search tfs_chk u_tfs_chk (.*);

FILE: bench/factor_search_checker.sv
// Checker that predicts each prescaler and period word and compares the results.
`timescale 1ns / 100ps

module factor_search_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [tfs_pkg::NW-1:0]        target_count_i,
  input  logic                          done_o,
  input  logic [tfs_pkg::CW-1:0]        prescale_count_o,
  input  logic [tfs_pkg::CW-1:0]        period_count_o,
  input  logic signed [tfs_pkg::EW-1:0] product_error_o,
  input  logic                          out_of_range_o,
  input  logic                          run_over_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   words_pending_o,
  output int unsigned                   words_checked_o,
  output int unsigned                   range_words_o
);

  localparam longint ERR_LIMIT = 65535;

  typedef struct packed {
    logic [tfs_pkg::CW-1:0]        prescale;
    logic [tfs_pkg::CW-1:0]        period;
    logic signed [tfs_pkg::EW-1:0] error;
    logic                          over_range;
  } factor_pair_t;

  factor_pair_t expected_pairs[$];
  int unsigned  fail_tally;
  int unsigned  checked_tally;
  int unsigned  range_tally;
  bit           leftovers_reported;

  // Walks the candidate prescalers the way the search does and keeps the first
  // pair with the smallest product error.
  function automatic factor_pair_t best_factor_pair(input logic [tfs_pkg::NW-1:0] target);
    longint       n;
    longint       maxc;
    longint       a;
    longint       b;
    longint       e;
    longint       e_mag;
    longint       best_a;
    longint       best_b;
    longint       best_mag;
    longint       err;
    bit           over_range;
    factor_pair_t pair;
    n = {32'd0, target};
    maxc = {48'd0, tfs_pkg::MAXC};
    over_range = 1'b0;
    if (n == 0) begin
      best_a = 1;
      best_b = 0;
      err = 0;
    end else if (n > maxc * maxc) begin
      over_range = 1'b1;
      best_a = maxc;
      best_b = maxc;
      err = maxc * maxc - n;
    end else begin
      best_a = (n - 1) / maxc + 1;
      best_b = (n / best_a) & maxc;
      best_mag = n;
      for (a = best_a; a < maxc - 1; a++) begin
        b = (n / a) & maxc;
        e = a * b - n;
        e_mag = (e < 0) ? -e : e;
        if (e_mag > a / 2) begin
          b = (b + 1) & maxc;
          e = a * b - n;
          e_mag = (e < 0) ? -e : e;
        end
        if (e_mag < best_mag) begin
          best_mag = e_mag;
          best_a = a;
          best_b = b;
          if (e == 0) break;
        end
      end
      err = best_a * best_b - n;
    end
    if (err > ERR_LIMIT) err = ERR_LIMIT;
    if (err < -ERR_LIMIT) err = -ERR_LIMIT;
    pair.prescale = best_a[tfs_pkg::CW-1:0];
    pair.period = best_b[tfs_pkg::CW-1:0];
    pair.error = err[tfs_pkg::EW-1:0];
    pair.over_range = over_range;
    return pair;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH @%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_tally++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    factor_pair_t want;
    if (!rst_ni) begin
      expected_pairs.delete();
      fail_tally = 0;
      checked_tally = 0;
      range_tally = 0;
      leftovers_reported = 1'b0;
      mismatch_count_o <= 0;
      words_pending_o <= 0;
      words_checked_o <= 0;
      range_words_o <= 0;
    end else begin
      if (start && !busy) begin
        expected_pairs.push_back(best_factor_pair(target_count_i));
      end
      if (done_o) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("result word with nothing expected, prescale", prescale_count_o, -1);
        end else begin
          want = expected_pairs.pop_front();
          checked_tally++;
          if (out_of_range_o) range_tally++;
          if (prescale_count_o !== want.prescale)
            report_mismatch("prescale_count", prescale_count_o, want.prescale);
          if (period_count_o !== want.period)
            report_mismatch("period_count", period_count_o, want.period);
          if (product_error_o !== want.error)
            report_mismatch("product_error", product_error_o, want.error);
          if (out_of_range_o !== want.over_range)
            report_mismatch("out_of_range", out_of_range_o, want.over_range);
        end
      end
      if (run_over_i && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        if (expected_pairs.size() != 0)
          report_mismatch("result words never delivered", 0, expected_pairs.size());
      end
      mismatch_count_o <= fail_tally;
      words_pending_o <= expected_pairs.size();
      words_checked_o <= checked_tally;
      range_words_o <= range_tally;
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the factor search bench: clock, reset, target stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 8_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_PER_PHASE = 34;
  localparam longint SPAN = 65535;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [tfs_pkg::NW-1:0]        target_count;
  logic                          done;
  logic [tfs_pkg::CW-1:0]        prescale_count;
  logic [tfs_pkg::CW-1:0]        period_count;
  logic signed [tfs_pkg::EW-1:0] product_error;
  logic                          out_of_range;
  logic                          run_over;
  int unsigned                   mismatch_count;
  int unsigned                   words_pending;
  int unsigned                   words_checked;
  int unsigned                   range_words;
  int unsigned                   quiet_cycles;
  int unsigned                   targets_sent;

  always #5 clk_i = ~clk_i;

  timer_divider_factor_search dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .target_count_i   (target_count),
    .done_o           (done),
    .prescale_count_o (prescale_count),
    .period_count_o   (period_count),
    .product_error_o  (product_error),
    .out_of_range_o   (out_of_range)
  );

  factor_search_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .target_count_i   (target_count),
    .done_o           (done),
    .prescale_count_o (prescale_count),
    .period_count_o   (period_count),
    .product_error_o  (product_error),
    .out_of_range_o   (out_of_range),
    .run_over_i       (run_over),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending),
    .words_checked_o  (words_checked),
    .range_words_o    (range_words)
  );

  // A long search accepts nothing until its result is shown, so the limit is
  // set well above the slowest full search.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d result words outstanding.", words_pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one target word; idle cycles drop start and put noise on the bus.
  task automatic send_target(input logic [tfs_pkg::NW-1:0] n, input int unsigned idle_pct);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if ($urandom_range(99, 0) >= idle_pct) begin
        start <= 1'b1;
        target_count <= n;
      end else begin
        start <= 1'b0;
        target_count <= $urandom();
      end
      @(posedge clk_i);
      taken = start && !busy;
    end
    targets_sent++;
  endtask

  task automatic wait_results_drained();
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // Random targets are kept to shapes that finish quickly: small counts and
  // exact products stop at the first prescaler, counts near the ceiling leave
  // only a few dozen candidates, and over-range counts skip the search.
  function automatic logic [tfs_pkg::NW-1:0] pick_target();
    int unsigned kind;
    longint      a;
    longint      b;
    longint      lo;
    longint      hi;
    kind = $urandom_range(99, 0);
    if (kind < 20) begin
      return $urandom_range(65535, 1);
    end else if (kind < 50) begin
      a = longint'($urandom_range(65535, 1));
      lo = SPAN - (SPAN - 1) / a;
      b = longint'($urandom_range(65535, 32'(lo)));
      return 32'(a * b);
    end else if (kind < 85) begin
      a = SPAN - longint'($urandom_range(42, 0));
      lo = SPAN * (a - 1) + 1;
      hi = SPAN * a;
      return $urandom_range(32'(hi), 32'(lo));
    end else begin
      return $urandom_range(32'hFFFF_FFFF, 32'hFFFE_0002);
    end
  endfunction

  initial begin
    logic [tfs_pkg::NW-1:0] corners[$];
    int unsigned            phase_idle[3];
    phase_idle = '{0, 60, 13};
    // Zero, small exact counts, a later exact prescaler, one long prime search,
    // the top of the prescaler range where the loop barely or never runs, the
    // square of the largest count, and targets past it.
    corners = '{32'd0, 32'd1, 32'd2, 32'd65534, 32'd65535, 32'd65536, 32'd131070,
                32'd196604, 32'h7FFF_FFFF, 32'd4294574086, 32'd4294639621,
                32'd4294705155, 32'd4294705156, 32'hFFFE_0001, 32'hFFFE_0002,
                32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF};
    targets_sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    target_count = '0;
    run_over = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (corners[i]) send_target(corners[i], 0);

    foreach (phase_idle[p]) begin
      @(negedge clk_i);
      start <= 1'b0;
      wait_results_drained();
      repeat (RANDOM_PER_PHASE) send_target(pick_target(), phase_idle[p]);
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    run_over <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Sent %0d targets: corner counts, then small, exact-product, near-ceiling",
             targets_sent);
    $display("and over-range mixes at 0, 60 and 13 percent sender idle;");
    $display("%0d words checked, %0d over range.", words_checked, range_words);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
